/* hdl/emf_pkg.sv */
package emf_pkg;

  // Ring and field widths.
  localparam int RING_DEPTH = 5;
  localparam int RING_IW    = 3;
  localparam int RAW_W      = 15;
  localparam int MM_W       = 16;

  // Arithmetic unit widths.
  localparam int MUL_W     = 17;
  localparam int PROD_W    = 2 * MUL_W;
  localparam int DIV_W     = 32;
  localparam int DIVISOR_W = 16;

  // Echo time to distance: mm = us * 343 / 2000.
  localparam logic [MUL_W-1:0]     US_TO_MM_MUL = 17'd343;
  localparam logic [DIVISOR_W-1:0] US_TO_MM_DIV = 16'd2000;

  // The hardware multiplies by 343 / 2000 scaled up by 2^27 and rounded up. The
  // rounding error stays below one part in 2000 for every 16-bit width, so the
  // top bits equal the truncated quotient.
  localparam int          US_TO_MM_SHIFT = 27;
  localparam int          CONV_W         = US_TO_MM_SHIFT + RAW_W;
  localparam logic [24:0] US_TO_MM_RECIP = 25'd23018341;

  // Median search: each round runs through the four queued entries and keeps the
  // smallest; the third round's minimum is the median.
  localparam int MED_STEPS  = RING_DEPTH - 1;
  localparam int MED_ROUNDS = RING_DEPTH / 2 + 1;
  localparam logic [RAW_W-1:0] MED_FILL = '1;

  // Register reset values.
  localparam logic [MM_W-1:0] MIN_MM_RST    = 16'd20;
  localparam logic [MM_W-1:0] MAX_MM_RST    = 16'd4000;
  localparam logic [3:0]      CAL_COUNT_RST = 4'd0;

  typedef enum logic [1:0] {
    CFG_MIN_MM    = 2'd0,
    CFG_MAX_MM    = 2'd1,
    CFG_CAL_COUNT = 2'd2
  } cfg_idx_t;

  typedef enum logic {
    OP_SAMPLE    = 1'b0,
    OP_CAL_WRITE = 1'b1
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CONV_MUL,
    ST_RING,
    ST_MED_LOAD,
    ST_MED_STEP,
    ST_MED_DROP,
    ST_CAL_FIRST,
    ST_CAL_LAST,
    ST_CAL_SCAN,
    ST_INT_MUL,
    ST_INT_DIV,
    ST_INT_WAIT,
    ST_INT_FIX,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_W-1:0]     dividend;
    logic [DIVISOR_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

/* hdl/emf_div.sv */
module emf_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  emf_pkg::div_req_t              req,
  output emf_pkg::div_stat_t             stat,
  output logic [emf_pkg::DIV_W-1:0]      quo
);
  import emf_pkg::*;

  localparam int CW = $clog2(DIV_W + 1);

  logic [DIV_W-1:0]     quo_r, quo_nxt;
  logic [DIVISOR_W-1:0] rem_r, rem_nxt;
  logic [DIVISOR_W-1:0] dvs_r, dvs_nxt;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIVISOR_W:0]   trial;
  logic [DIVISOR_W:0]   diff;
  logic                 fits;

  // Restoring division, one quotient bit per cycle, MSB first.
  always_comb begin
    trial    = {rem_r, quo_r[DIV_W-1]};
    diff     = trial - {1'b0, dvs_r};
    fits     = (trial >= {1'b0, dvs_r});
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      quo_nxt  = req.dividend;
      rem_nxt  = '0;
      dvs_nxt  = req.divisor;
      cnt_nxt  = CW'(DIV_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      quo_nxt = {quo_r[DIV_W-2:0], fits};
      rem_nxt = fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quo       = quo_r;

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |-> !busy_r)
    else $error("divider started while busy");

  a_divisor_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |-> (req.divisor != '0))
    else $error("divider started with a zero divisor");

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (rem_r < dvs_r))
    else $error("partial remainder not below divisor");

endmodule

/* hdl/echo_median_calibrate_filter_top.sv */
// Channel  Direction  Handshake          Payload
// in_      input      in_valid/in_ready  operation, echo_ok, echo_us, point_index,
//                                        point_raw, point_true
// out_     output     out_valid/out_ready valid_res, raw_mm, smooth_mm, distance_mm
// cfg_     input      cfg_valid/cfg_ready cfg_index, cfg_data
//
// A calibration write item is taken while the sequencer stays idle and yields no result.
// A rejected sample item passes the conversion and ring steps and goes to the output
// register. An accepted one also runs the median search once the ring is full, the
// calibration lookup with its segment scan and, inside a segment, the interpolation,
// which waits on the restoring divider. The unit conversion is a single reciprocal
// multiplication.
// Reset is synchronous and active low; it restores the control registers, empties the
// ring and clears all calibration points. The ring entries themselves are not cleared.
// The block takes one item at a time; in_ready is high only while the sequencer is idle.
// A finished result sits in the output register, so the next item may be
// accepted while out_ready holds it back.
module echo_median_calibrate_filter_top #(
  parameter int CAL_POINTS = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,

  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_operation,
  input  logic                          in_echo_ok,
  input  logic [15:0]                   in_echo_us,
  input  logic [2:0]                    in_point_index,
  input  logic [emf_pkg::MM_W-1:0]      in_point_raw,
  input  logic [emf_pkg::MM_W-1:0]      in_point_true,

  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_valid_res,
  output logic [emf_pkg::RAW_W-1:0]     out_raw_mm,
  output logic [emf_pkg::RAW_W-1:0]     out_smooth_mm,
  output logic [emf_pkg::MM_W-1:0]      out_distance_mm,

  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [1:0]                    cfg_index,
  input  logic [emf_pkg::MM_W-1:0]      cfg_data
);
  import emf_pkg::*;

  // Address width of the calibration tables and width of a point count.
  localparam int CIW = $clog2(CAL_POINTS);
  localparam int CNW = $clog2(CAL_POINTS + 1);

  // Sequencer.
  state_t state_r, state_nxt;

  // Configuration registers.
  logic [MM_W-1:0] min_r;
  logic [MM_W-1:0] max_r;
  logic [3:0]      cal_count_r;

  // Calibration points; reset clears them.
  logic [MM_W-1:0] cal_raw_r  [CAL_POINTS];
  logic [MM_W-1:0] cal_true_r [CAL_POINTS];

  // Sample ring and its bookkeeping.
  logic [RAW_W-1:0]   sample_ring_r [RING_DEPTH];
  logic [RING_IW-1:0] ring_pos_r;
  logic [RING_IW-1:0] fill_r;

  // Item payload and working registers.
  logic                   ok_r;
  logic [15:0]            us_r;
  logic signed [PROD_W-1:0] prod_r;
  logic                   neg_r;
  logic                   acc_r;
  logic [RAW_W-1:0]       raw_r;
  logic [RAW_W-1:0]       smooth_r;
  logic [MM_W-1:0]        cal_val_r;
  logic [MM_W-1:0]        r0_r;
  logic [MM_W-1:0]        t0_r;
  logic [MM_W-1:0]        t1_r;
  logic [DIVISOR_W-1:0]   den_r;
  logic [CNW-1:0]         scan_idx_r;

  // Median search queue.
  logic [RAW_W-1:0] med_q_r [MED_STEPS];
  logic [RAW_W-1:0] cand_r;
  logic [1:0]       step_r;
  logic [1:0]       round_r;

  // Output register.
  logic             out_valid_r;
  logic             out_valid_res_r;
  logic [RAW_W-1:0] out_raw_r;
  logic [RAW_W-1:0] out_smooth_r;
  logic [MM_W-1:0]  out_dist_r;

  // Arithmetic units.
  div_req_t                 div_req;
  div_stat_t                div_stat;
  logic [DIV_W-1:0]         div_quo;
  logic signed [MUL_W-1:0]  mul_a;
  logic signed [MUL_W-1:0]  mul_b;
  logic signed [PROD_W-1:0] mul_p;

  // Combinational helpers.
  logic                     in_acc;
  logic                     cal_we;
  logic [CNW-1:0]           cal_n;
  logic [CNW-1:0]           last_idx;
  logic [CIW-1:0]           cal_addr;
  logic [MM_W-1:0]          cal_rd_raw;
  logic [MM_W-1:0]          cal_rd_true;
  logic [MM_W-1:0]          v16;
  logic [CONV_W-1:0]        conv_p;
  logic [RAW_W-1:0]         conv_raw;
  logic                     reject;
  logic [RING_IW-1:0]       fill_inc;
  logic [RING_IW-1:0]       pos_next;
  logic                     seg_hit;
  logic [RAW_W-1:0]         med_lo;
  logic [RAW_W-1:0]         med_hi;
  logic                     med_last_step;
  logic                     med_last_round;
  logic signed [PROD_W-1:0] prod_abs;
  logic signed [17:0]       q_s;
  logic signed [17:0]       q_adj;
  logic signed [17:0]       interp;
  logic [MM_W-1:0]          interp_sat;
  logic [MM_W-1:0]          clamp_v;
  logic                     out_load;

  emf_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .stat  (div_stat),
    .quo   (div_quo)
  );

  assign mul_p = mul_a * mul_b;

  always_comb begin
    in_acc   = in_valid && in_ready;
    cal_we   = in_acc && (in_operation == OP_CAL_WRITE) &&
               (32'(in_point_index) < CAL_POINTS);
    cal_n    = (32'(cal_count_r) > CAL_POINTS) ? CNW'(CAL_POINTS) : CNW'(cal_count_r);
    last_idx = cal_n - CNW'(1);
    v16      = {1'b0, smooth_r};
    // Echo width to millimetres as a constant multiplication by the scaled reciprocal.
    conv_p   = CONV_W'(us_r) * CONV_W'(US_TO_MM_RECIP);
    conv_raw = conv_p[US_TO_MM_SHIFT +: RAW_W];
    reject   = !ok_r || ({1'b0, raw_r} < min_r);
    fill_inc = (fill_r < RING_IW'(RING_DEPTH)) ? fill_r + RING_IW'(1) : fill_r;
    pos_next = (ring_pos_r == RING_IW'(RING_DEPTH - 1)) ? '0 : ring_pos_r + RING_IW'(1);
    cal_rd_raw  = cal_raw_r[cal_addr];
    cal_rd_true = cal_true_r[cal_addr];
    seg_hit  = (r0_r <= v16) && (v16 <= cal_rd_raw);
    med_lo   = (cand_r <= med_q_r[0]) ? cand_r : med_q_r[0];
    med_hi   = (cand_r <= med_q_r[0]) ? med_q_r[0] : cand_r;
    med_last_step  = (step_r == 2'(MED_STEPS - 1));
    med_last_round = (round_r == 2'(MED_ROUNDS - 1));
    prod_abs = prod_r[PROD_W-1] ? -prod_r : prod_r;
    // The quotient magnitude never exceeds the true-value step, so 17 bits hold it.
    q_s      = signed'({1'b0, div_quo[16:0]});
    q_adj    = neg_r ? -q_s : q_s;
    interp   = signed'({2'b00, t0_r}) + q_adj;
    if (interp < 0) begin
      interp_sat = '0;
    end else if (interp > 18'sd65535) begin
      interp_sat = '1;
    end else begin
      interp_sat = interp[MM_W-1:0];
    end
    // With crossed bounds, a value below min_r gets min_r and any other gets max_r.
    if (cal_val_r < min_r) begin
      clamp_v = min_r;
    end else if (cal_val_r > max_r) begin
      clamp_v = max_r;
    end else begin
      clamp_v = cal_val_r;
    end
    out_load = (state_r == ST_OUT) && (!out_valid_r || out_ready);
  end

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid && (in_operation == OP_SAMPLE)) begin
          state_nxt = ST_CONV_MUL;
        end
      end
      ST_CONV_MUL:  state_nxt = ST_RING;
      ST_RING: begin
        if (reject) begin
          state_nxt = ST_OUT;
        end else if (fill_inc == RING_IW'(RING_DEPTH)) begin
          state_nxt = ST_MED_LOAD;
        end else begin
          state_nxt = ST_CAL_FIRST;
        end
      end
      ST_MED_LOAD: state_nxt = ST_MED_STEP;
      ST_MED_STEP: begin
        if (med_last_step) begin
          state_nxt = med_last_round ? ST_CAL_FIRST : ST_MED_DROP;
        end
      end
      ST_MED_DROP: state_nxt = ST_MED_STEP;
      ST_CAL_FIRST: begin
        if ((cal_n < CNW'(2)) || (v16 <= cal_rd_raw)) begin
          state_nxt = ST_OUT;
        end else begin
          state_nxt = ST_CAL_LAST;
        end
      end
      ST_CAL_LAST: begin
        state_nxt = (v16 >= cal_rd_raw) ? ST_OUT : ST_CAL_SCAN;
      end
      ST_CAL_SCAN: begin
        if (seg_hit) begin
          state_nxt = (cal_rd_raw == r0_r) ? ST_OUT : ST_INT_MUL;
        end else if (scan_idx_r == last_idx) begin
          state_nxt = ST_OUT;
        end
      end
      ST_INT_MUL:  state_nxt = ST_INT_DIV;
      ST_INT_DIV:  state_nxt = ST_INT_WAIT;
      ST_INT_WAIT: begin
        if (div_stat.done) begin
          state_nxt = ST_INT_FIX;
        end
      end
      ST_INT_FIX: state_nxt = ST_OUT;
      ST_OUT: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs: handshake, arithmetic unit operands and table address.
  always_comb begin
    in_ready         = (state_r == ST_IDLE);
    mul_a            = signed'({1'b0, v16 - r0_r});
    mul_b            = signed'({1'b0, t1_r}) - signed'({1'b0, t0_r});
    div_req.start    = 1'b0;
    div_req.dividend = prod_abs[DIV_W-1:0];
    div_req.divisor  = den_r;
    cal_addr         = scan_idx_r[CIW-1:0];
    case (state_r)
      ST_INT_DIV:   div_req.start = 1'b1;
      ST_CAL_FIRST: cal_addr = '0;
      ST_CAL_LAST:  cal_addr = last_idx[CIW-1:0];
      default: ;
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      min_r       <= MIN_MM_RST;
      max_r       <= MAX_MM_RST;
      cal_count_r <= CAL_COUNT_RST;
      ring_pos_r  <= '0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < CAL_POINTS; i++) begin
        cal_raw_r[i]  <= '0;
        cal_true_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_MIN_MM:    min_r       <= cfg_data;
          CFG_MAX_MM:    max_r       <= cfg_data;
          CFG_CAL_COUNT: cal_count_r <= cfg_data[3:0];
          default: ;
        endcase
      end
      if (cal_we) begin
        cal_raw_r[CIW'(in_point_index)]  <= in_point_raw;
        cal_true_r[CIW'(in_point_index)] <= in_point_true;
      end
      // A rejected sample restarts the fill; an accepted one advances the ring.
      if (state_r == ST_RING) begin
        if (reject) begin
          ring_pos_r <= '0;
          fill_r     <= '0;
        end else begin
          ring_pos_r <= pos_next;
          fill_r     <= fill_inc;
        end
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        ok_r <= in_echo_ok;
        us_r <= in_echo_us;
      end
      ST_CONV_MUL: raw_r <= conv_raw;
      ST_RING: begin
        smooth_r <= raw_r;
        acc_r    <= !reject;
        if (!reject) begin
          sample_ring_r[ring_pos_r] <= raw_r;
        end
      end
      ST_MED_LOAD: begin
        cand_r  <= sample_ring_r[0];
        for (int i = 0; i < MED_STEPS; i++) begin
          med_q_r[i] <= sample_ring_r[i + 1];
        end
        step_r  <= '0;
        round_r <= '0;
      end
      ST_MED_STEP: begin
        // Rotate the queue; the smaller value stays as the candidate.
        for (int i = 0; i < MED_STEPS - 1; i++) begin
          med_q_r[i] <= med_q_r[i + 1];
        end
        med_q_r[MED_STEPS-1] <= med_hi;
        cand_r   <= med_lo;
        step_r   <= step_r + 2'd1;
        smooth_r <= med_lo;
      end
      ST_MED_DROP: begin
        // Discard the round's minimum and pad the queue with a value that never wins.
        cand_r <= med_q_r[0];
        for (int i = 0; i < MED_STEPS - 1; i++) begin
          med_q_r[i] <= med_q_r[i + 1];
        end
        med_q_r[MED_STEPS-1] <= MED_FILL;
        step_r  <= '0;
        round_r <= round_r + 2'd1;
      end
      ST_CAL_FIRST: begin
        r0_r       <= cal_rd_raw;
        t0_r       <= cal_rd_true;
        scan_idx_r <= CNW'(1);
        if (cal_n < CNW'(2)) begin
          cal_val_r <= v16;
        end else begin
          cal_val_r <= cal_rd_true;
        end
      end
      ST_CAL_LAST: cal_val_r <= cal_rd_true;
      ST_CAL_SCAN: begin
        if (seg_hit) begin
          cal_val_r <= t0_r;
          t1_r      <= cal_rd_true;
          den_r     <= cal_rd_raw - r0_r;
        end else begin
          // Points that never bracket the value leave it uncalibrated.
          cal_val_r  <= v16;
          r0_r       <= cal_rd_raw;
          t0_r       <= cal_rd_true;
          scan_idx_r <= scan_idx_r + CNW'(1);
        end
      end
      ST_INT_MUL: prod_r <= mul_p;
      ST_INT_DIV: neg_r  <= prod_r[PROD_W-1];
      ST_INT_FIX: cal_val_r <= interp_sat;
      ST_OUT: begin
        if (out_load) begin
          out_valid_res_r <= acc_r;
          out_raw_r       <= acc_r ? raw_r : '0;
          out_smooth_r    <= acc_r ? smooth_r : '0;
          out_dist_r      <= acc_r ? clamp_v : '0;
        end
      end
      default: ;
    endcase
  end

  assign cfg_ready       = 1'b1;
  assign out_valid       = out_valid_r;
  assign out_valid_res   = out_valid_res_r;
  assign out_raw_mm      = out_raw_r;
  assign out_smooth_mm   = out_smooth_r;
  assign out_distance_mm = out_dist_r;

  a_fill_tracks_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (fill_r < RING_IW'(RING_DEPTH)) |-> (ring_pos_r == fill_r))
    else $error("ring position out of step with fill count");

  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_valid_res_r) |->
      ((out_raw_r == '0) && (out_smooth_r == '0) && (out_dist_r == '0)))
    else $error("rejected sample carries nonzero fields");

  a_idle_div_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !div_stat.busy)
    else $error("divider still busy while sequencer idle");

endmodule
